[src/jst_pkg.sv]
// Shared types, codes and helper functions of the JSON stream tokenizer.
package jst_pkg;

  typedef enum logic [3:0] {
    EV_START_DOC  = 4'd0,
    EV_END_DOC    = 4'd1,
    EV_ARR_START  = 4'd2,
    EV_ARR_END    = 4'd3,
    EV_OBJ_START  = 4'd4,
    EV_OBJ_END    = 4'd5,
    EV_KEY_BYTE   = 4'd6,
    EV_KEY_END    = 4'd7,
    EV_STR_BYTE   = 4'd8,
    EV_STR_END    = 4'd9,
    EV_NUM_BYTE   = 4'd10,
    EV_NUM_END    = 4'd11,
    EV_TRUE       = 4'd12,
    EV_FALSE      = 4'd13,
    EV_NULL       = 4'd14,
    EV_ERROR      = 4'd15
  } ev_e;

  typedef enum logic [1:0] {
    K_OBJECT = 2'd0,
    K_ARRAY  = 2'd1,
    K_KEY    = 2'd2,
    K_STRING = 2'd3
  } kind_e;

  localparam logic [4:0] ERR_DEPTH       = 5'd1;
  localparam logic [4:0] ERR_CTRL_CHAR   = 5'd2;
  localparam logic [4:0] ERR_KEY_QUOTE   = 5'd3;
  localparam logic [4:0] ERR_COLON       = 5'd4;
  localparam logic [4:0] ERR_OBJ_SEP     = 5'd5;
  localparam logic [4:0] ERR_ARR_SEP     = 5'd6;
  localparam logic [4:0] ERR_NO_CONT     = 5'd7;
  localparam logic [4:0] ERR_TWO_POINTS  = 5'd8;
  localparam logic [4:0] ERR_POINT_EXP   = 5'd9;
  localparam logic [4:0] ERR_TWO_EXP     = 5'd10;
  localparam logic [4:0] ERR_SIGN_EMPTY  = 5'd11;
  localparam logic [4:0] ERR_SIGN_POS    = 5'd12;
  localparam logic [4:0] ERR_DOC_START   = 5'd13;
  localparam logic [4:0] ERR_TOO_LONG    = 5'd14;
  localparam logic [4:0] ERR_VALUE_CHAR  = 5'd15;
  localparam logic [4:0] ERR_ARR_EMPTY   = 5'd16;
  localparam logic [4:0] ERR_ARR_MISM    = 5'd17;
  localparam logic [4:0] ERR_OBJ_EMPTY   = 5'd18;
  localparam logic [4:0] ERR_OBJ_MISM    = 5'd19;
  localparam logic [4:0] ERR_ESCAPE      = 5'd20;
  localparam logic [4:0] ERR_HEX         = 5'd21;
  localparam logic [4:0] ERR_TRUE        = 5'd22;
  localparam logic [4:0] ERR_FALSE       = 5'd23;
  localparam logic [4:0] ERR_NULL        = 5'd24;

  localparam int unsigned OQ_DEPTH = 8;
  localparam int unsigned OQ_AW    = 3;

  typedef struct packed {
    logic       action;
    logic [7:0] byte_in;
    logic       is_ws;
    logic       is_digit;
    logic       is_hex;
    logic [3:0] hex_val;
    logic       is_ctrl;
  } cls_t;

  typedef struct packed {
    ev_e                event_res;
    logic [7:0]         data_byte;
    logic signed [63:0] int_value;
    logic               is_float;
    logic [4:0]         error_code;
  } ev_t;

  typedef struct packed {
    ev_t  ev;
    logic last;
  } out_t;

  typedef struct packed {
    logic [1:0] cnt;
    out_t       e0;
    out_t       e1;
    out_t       e2;
  } push_t;

  function automatic ev_t mk_ev(ev_e e, logic [7:0] b, logic [63:0] v, logic f,
                                logic [4:0] er);
    ev_t r;
    r.event_res  = e;
    r.data_byte  = b;
    r.int_value  = v;
    r.is_float   = f;
    r.error_code = er;
    return r;
  endfunction

  function automatic logic [7:0] lit_char(logic [1:0] k, logic [2:0] idx);
    logic [7:0] r;
    r = 8'h00;
    unique case (k)
      2'd0: begin
        unique case (idx)
          3'd0: r = "t";
          3'd1: r = "r";
          3'd2: r = "u";
          3'd3: r = "e";
          default: r = 8'h00;
        endcase
      end
      2'd1: begin
        unique case (idx)
          3'd0: r = "f";
          3'd1: r = "a";
          3'd2: r = "l";
          3'd3: r = "s";
          3'd4: r = "e";
          default: r = 8'h00;
        endcase
      end
      default: begin
        unique case (idx)
          3'd0: r = "n";
          3'd1: r = "u";
          3'd2: r = "l";
          3'd3: r = "l";
          default: r = 8'h00;
        endcase
      end
    endcase
    return r;
  endfunction

endpackage

[src/jst_if.sv]
// Valid/ready channel interfaces for input bytes and output events.
interface jst_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] byte_in;
  modport source (output valid, action, byte_in, input ready);
  modport sink (input valid, action, byte_in, output ready);
endinterface

interface jst_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  event_res;
  logic [7:0]  data_byte;
  logic signed [63:0] int_value;
  logic        is_float;
  logic [4:0]  error_code;
  logic        last;
  modport source (output valid, event_res, data_byte, int_value, is_float, error_code, last,
                  input ready);
  modport sink (input valid, event_res, data_byte, int_value, is_float, error_code, last,
                output ready);
endinterface

[src/jst_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module jst_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[src/jst_front.sv]
// Input stage: accept beats, classify the byte and queue it for the engine.
module jst_front import jst_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  jst_in_if.sink in_i,
  output logic   valid_o,
  input  logic   ready_i,
  output cls_t   cls_o
);
  cls_t       ent_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  cls_t       cls;
  logic       push, pop;
  logic [7:0] b;

  always_comb begin
    b            = in_i.byte_in;
    cls.action   = in_i.action;
    cls.byte_in  = b;
    cls.is_ws    = (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0D);
    cls.is_digit = (b >= "0") && (b <= "9");
    cls.is_ctrl  = (b <= 8'h1F) || (b == 8'h7F);
    cls.is_hex   = 1'b1;
    cls.hex_val  = 4'd0;
    if ((b >= "0") && (b <= "9")) begin
      cls.hex_val = 4'(b - "0");
    end else if ((b >= "a") && (b <= "f")) begin
      cls.hex_val = 4'(b - "a" + 8'd10);
    end else if ((b >= "A") && (b <= "F")) begin
      cls.hex_val = 4'(b - "A" + 8'd10);
    end else begin
      cls.is_hex = 1'b0;
    end
  end

  assign in_i.ready = (cnt_q != 2'd2);
  assign push       = in_i.valid && in_i.ready;
  assign valid_o    = (cnt_q != 2'd0);
  assign pop        = valid_o && ready_i;
  assign cls_o      = ent_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

[src/jst_engine.sv]
// Parser engine: advance the tokenizer state per byte and produce events.
module jst_engine import jst_pkg::*; #(
  parameter int unsigned MAX_NEST_DEPTH   = 32,
  parameter int unsigned MAX_TOKEN_LENGTH = 256
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  cls_t  cls_i,
  input  logic  space_i,
  output push_t push_o
);
  localparam int unsigned DW = $clog2(MAX_NEST_DEPTH + 1);
  localparam int unsigned AW = $clog2(MAX_NEST_DEPTH);
  localparam int unsigned CW = $clog2(MAX_TOKEN_LENGTH);
  localparam logic [DW-1:0] DEPTH_MAX = DW'(MAX_NEST_DEPTH);
  localparam logic [DW-1:0] DEPTH_LIM = DW'(MAX_NEST_DEPTH - 1);
  localparam logic [CW-1:0] CL_LIM    = CW'(MAX_TOKEN_LENGTH - 1);
  localparam logic [63:0]   CAP       = 64'h8000_0000_0000_0000;

  typedef enum logic [4:0] {
    M_START, M_IN_ARRAY, M_IN_OBJECT, M_END_KEY, M_AFTER_KEY, M_AFTER_VALUE,
    M_IN_STRING, M_ESCAPE, M_UNICODE, M_NUMBER, M_LIT_T, M_LIT_F, M_LIT_N,
    M_BAD_T, M_BAD_F, M_BAD_N
  } mode_e;

  typedef enum logic {PH_RUN, PH_TOP} phase_e;

  mode_e       mode_q, mode_d;
  phase_e      phase_q, phase_d;
  logic [DW-1:0] depth_q, depth_d;
  logic [CW-1:0] cl_q, cl_d;
  logic        qs_q, qs_d, sp_q, sp_d, se_q, se_d, neg_q, neg_d, err_q, err_d;
  logic [7:0]  prev_q, prev_d;
  logic [63:0] acc_q, acc_d;
  logic [2:0]  lit_q, lit_d, hex_q, hex_d;
  logic [15:0] cp_q, cp_d;
  kind_e       top_q, top_d;
  logic        redo_q, redo_d, pend_q, pend_d;
  cls_t        cur_q, cur;
  ev_t         pev_q, pev_d;

  ev_t         evs [2];
  logic [1:0]  n;
  logic        go;
  logic        push_en, fetch;
  kind_e       push_kind;
  logic        do_open, do_close, do_start, do_cont;
  kind_e       open_kind, close_kind;
  logic [7:0]  cont_b;
  ev_e         cont_ev, text_ev;
  logic        top_none;
  logic [7:0]  c, delim, esc;
  logic        esc_ok;
  logic [67:0] prod;
  logic [63:0] num_v;
  logic [1:0]  lk;
  logic [15:0] cpn;
  logic [2:0]  hexn;
  logic [1:0]  ram_rd;
  logic [DW-1:0] rd_idx;

  assign go      = (phase_q == PH_RUN) && space_i && (redo_q || valid_i);
  assign ready_o = (phase_q == PH_RUN) && space_i && !redo_q;
  assign cur     = redo_q ? cur_q : cls_i;
  assign c       = cur.byte_in;
  assign delim   = qs_q ? "'" : "\"";
  assign top_none = (depth_q == '0);
  assign text_ev = (!top_none && top_q == K_KEY) ? EV_KEY_BYTE : EV_STR_BYTE;
  assign prod    = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1) + 68'(cur.hex_val);
  assign num_v   = neg_q ? (64'd0 - acc_q) : (acc_q[63] ? (CAP - 64'd1) : acc_q);

  always_comb begin
    esc_ok = 1'b1;
    esc    = c;
    if ((c == delim) || (c == "\\") || (c == "/")) esc = c;
    else if (c == "b") esc = 8'h08;
    else if (c == "f") esc = 8'h0C;
    else if (c == "n") esc = 8'h0A;
    else if (c == "r") esc = 8'h0D;
    else if (c == "t") esc = 8'h09;
    else esc_ok = 1'b0;
  end

  always_comb begin
    unique case (mode_q)
      M_LIT_T, M_BAD_T: lk = 2'd0;
      M_LIT_F, M_BAD_F: lk = 2'd1;
      default:          lk = 2'd2;
    endcase
  end

  always_comb begin
    mode_d = mode_q; depth_d = depth_q; cl_d = cl_q; qs_d = qs_q; sp_d = sp_q;
    se_d = se_q; neg_d = neg_q; err_d = err_q; prev_d = prev_q; acc_d = acc_q;
    lit_d = lit_q; hex_d = hex_q; cp_d = cp_q; top_d = top_q; redo_d = 1'b0;
    evs[0] = '0; evs[1] = '0; n = 2'd0;
    push_en = 1'b0; push_kind = K_OBJECT; fetch = 1'b0;
    do_open = 1'b0; do_close = 1'b0; do_start = 1'b0; do_cont = 1'b0;
    open_kind = K_ARRAY; close_kind = K_ARRAY; cont_b = 8'h00; cont_ev = EV_STR_BYTE;
    cpn = cp_q; hexn = hex_q;
    if (go) begin
      if (cur.action) begin
        mode_d = M_START; depth_d = '0; cl_d = '0; qs_d = 1'b0; sp_d = 1'b0;
        se_d = 1'b0; neg_d = 1'b0; err_d = 1'b0; prev_d = 8'h00; acc_d = '0;
        lit_d = '0; hex_d = '0; cp_d = '0;
      end else if (err_q) begin
        err_d = 1'b1;
      end else if (depth_q >= DEPTH_LIM) begin
        evs[n[0]] = mk_ev(EV_ERROR, '0, '0, 1'b0, ERR_DEPTH); n = n + 2'd1; err_d = 1'b1;
      end else if (cur.is_ws && !((mode_q == M_IN_STRING) || (mode_q == M_UNICODE) ||
                                  (mode_q == M_ESCAPE) || (mode_q == M_NUMBER))) begin
        err_d = 1'b0;
      end else begin
        unique case (mode_q)
          M_START: begin
            evs[n[0]] = mk_ev(EV_START_DOC, '0, '0, 1'b0, '0); n = n + 2'd1;
            if (c == "[") begin
              do_open = 1'b1; open_kind = K_ARRAY;
            end else if (c == "{") begin
              do_open = 1'b1; open_kind = K_OBJECT;
            end else begin
              evs[n[0]] = mk_ev(EV_ERROR, '0, '0, 1'b0, ERR_DOC_START); n = n + 2'd1;
              err_d = 1'b1;
            end
          end
          M_IN_ARRAY: begin
            if (c == "]") begin
              do_close = 1'b1; close_kind = K_ARRAY;
            end else begin
              do_start = 1'b1;
            end
          end
          M_IN_OBJECT: begin
            if (c == "}") begin
              do_close = 1'b1; close_kind = K_OBJECT;
            end else if ((c == "\"") || (c == "'")) begin
              push_en = 1'b1; push_kind = K_KEY; mode_d = M_IN_STRING; qs_d = (c == "'");
            end else begin
              evs[n[0]] = mk_ev(EV_ERROR, '0, '0, 1'b0, ERR_KEY_QUOTE); n = n + 2'd1;
              err_d = 1'b1;
            end
          end
          M_END_KEY: begin
            if (c == ":") begin
              mode_d = M_AFTER_KEY;
            end else begin
              evs[n[0]] = mk_ev(EV_ERROR, '0, '0, 1'b0, ERR_COLON); n = n + 2'd1;
              err_d = 1'b1;
            end
          end
          M_AFTER_KEY: do_start = 1'b1;
          M_AFTER_VALUE: begin
            if (!top_none && top_q == K_OBJECT) begin
              if (c == "}") begin
                do_close = 1'b1; close_kind = K_OBJECT;
              end else if (c == ",") begin
                mode_d = M_IN_OBJECT;
              end else begin
                evs[n[0]] = mk_ev(EV_ERROR, '0, '0, 1'b0, ERR_OBJ_SEP); n = n + 2'd1;
                err_d = 1'b1;
              end
            end else if (!top_none && top_q == K_ARRAY) begin
              if (c == "]") begin
                do_close = 1'b1; close_kind = K_ARRAY;
              end else if (c == ",") begin
                mode_d = M_IN_ARRAY;
              end else begin
                evs[n[0]] = mk_ev(EV_ERROR, '0, '0, 1'b0, ERR_ARR_SEP); n = n + 2'd1;
                err_d = 1'b1;
              end
            end else begin
              evs[n[0]] = mk_ev(EV_ERROR, '0, '0, 1'b0, ERR_NO_CONT); n = n + 2'd1;
              err_d = 1'b1;
            end
          end
          M_IN_STRING: begin
            if (c == delim) begin
              if (!top_none) begin
                depth_d = depth_q - DW'(1); fetch = (depth_d != '0);
              end
              if (!top_none && top_q == K_KEY) begin
                evs[n[0]] = mk_ev(EV_KEY_END, '0, '0, 1'b0, '0); n = n + 2'd1;
                mode_d = M_END_KEY;
              end else begin
                evs[n[0]] = mk_ev(EV_STR_END, '0, '0, 1'b0, '0); n = n + 2'd1;
                mode_d = M_AFTER_VALUE;
              end
              cl_d = '0; qs_d = 1'b0;
            end else if (c == "\\") begin
              mode_d = M_ESCAPE;
            end else if (cur.is_ctrl) begin
              evs[n[0]] = mk_ev(EV_ERROR, '0, '0, 1'b0, ERR_CTRL_CHAR); n = n + 2'd1;
              err_d = 1'b1;
            end else begin
              do_cont = 1'b1; cont_b = c; cont_ev = text_ev;
            end
          end
          M_ESCAPE: begin
            if (c == "u") begin
              mode_d = M_UNICODE; hex_d = '0; cp_d = '0;
            end else if (esc_ok) begin
              do_cont = 1'b1; cont_b = esc; cont_ev = text_ev; mode_d = M_IN_STRING;
            end else begin
              evs[n[0]] = mk_ev(EV_ERROR, '0, '0, 1'b0, ERR_ESCAPE); n = n + 2'd1;
              err_d = 1'b1;
            end
          end
          M_UNICODE: begin
            if (!cur.is_hex) begin
              evs[n[0]] = mk_ev(EV_ERROR, '0, '0, 1'b0, ERR_HEX); n = n + 2'd1;
              err_d = 1'b1;
            end else begin
              cpn = {cp_q[11:0], cur.hex_val};
              hexn = hex_q + 3'd1;
              cp_d = cpn; hex_d = hexn;
              if (hexn >= 3'd4) begin
                if (cpn < 16'h0080) begin
                  do_cont = 1'b1; cont_b = cpn[7:0]; cont_ev = text_ev;
                end else if (cpn < 16'h0800) begin
                  if (cl_q >= CL_LIM) begin
                    evs[n[0]] = mk_ev(EV_ERROR, '0, '0, 1'b0, ERR_TOO_LONG); n = n + 2'd1;
                    err_d = 1'b1;
                  end else begin
                    evs[n[0]] = mk_ev(text_ev, 8'(cpn[10:6]) | 8'hC0, '0, 1'b0, '0);
                    n = n + 2'd1;
                    cl_d = cl_q + CW'(1);
                    do_cont = 1'b1; cont_b = 8'(cpn[5:0]) | 8'h80; cont_ev = text_ev;
                  end
                end else if (cpn == 16'h2019) begin
                  do_cont = 1'b1; cont_b = "'"; cont_ev = text_ev;
                end else begin
                  do_cont = 1'b1; cont_b = " "; cont_ev = text_ev;
                end
                hex_d = '0; mode_d = M_IN_STRING;
              end
            end
          end
          M_NUMBER: begin
            if (cur.is_digit) begin
              if (!(sp_q || se_q)) acc_d = (prod > {4'd0, CAP}) ? CAP : prod[63:0];
              prev_d = c; do_cont = 1'b1; cont_b = c; cont_ev = EV_NUM_BYTE;
            end else if (c == ".") begin
              if (sp_q) begin
                evs[n[0]] = mk_ev(EV_ERROR, '0, '0, 1'b0, ERR_TWO_POINTS); n = n + 2'd1;
                err_d = 1'b1;
              end else if (se_q) begin
                evs[n[0]] = mk_ev(EV_ERROR, '0, '0, 1'b0, ERR_POINT_EXP); n = n + 2'd1;
                err_d = 1'b1;
              end else begin
                sp_d = 1'b1; prev_d = c; do_cont = 1'b1; cont_b = c; cont_ev = EV_NUM_BYTE;
              end
            end else if ((c == "e") || (c == "E")) begin
              if (se_q) begin
                evs[n[0]] = mk_ev(EV_ERROR, '0, '0, 1'b0, ERR_TWO_EXP); n = n + 2'd1;
                err_d = 1'b1;
              end else begin
                se_d = 1'b1; prev_d = c; do_cont = 1'b1; cont_b = c; cont_ev = EV_NUM_BYTE;
              end
            end else if ((c == "+") || (c == "-")) begin
              if (cl_q == '0) begin
                evs[n[0]] = mk_ev(EV_ERROR, '0, '0, 1'b0, ERR_SIGN_EMPTY); n = n + 2'd1;
                err_d = 1'b1;
              end else if (!((prev_q == "e") || (prev_q == "E"))) begin
                evs[n[0]] = mk_ev(EV_ERROR, '0, '0, 1'b0, ERR_SIGN_POS); n = n + 2'd1;
                err_d = 1'b1;
              end else begin
                prev_d = c; do_cont = 1'b1; cont_b = c; cont_ev = EV_NUM_BYTE;
              end
            end else begin
              evs[n[0]] = mk_ev(EV_NUM_END, '0, num_v, sp_q, '0); n = n + 2'd1;
              cl_d = '0; mode_d = M_AFTER_VALUE; redo_d = 1'b1;
            end
          end
          default: begin
            if ((lit_q < 3'd5) && (c != lit_char(lk, lit_q)) && (mode_q < M_BAD_T)) begin
              mode_d = mode_e'(5'(M_BAD_T) + 5'(lk));
            end
            lit_d = lit_q + 3'd1;
            if (lit_d >= ((lk == 2'd1) ? 3'd5 : 3'd4)) begin
              if (mode_d >= M_BAD_T) begin
                evs[n[0]] = mk_ev(EV_ERROR, '0, '0, 1'b0, ERR_TRUE + 5'(lk));
                n = n + 2'd1; err_d = 1'b1;
              end else begin
                evs[n[0]] = mk_ev(ev_e'(4'(EV_TRUE) + 4'(lk)), '0, '0, 1'b0, '0);
                n = n + 2'd1; mode_d = M_AFTER_VALUE; lit_d = '0;
              end
            end
          end
        endcase

        if (do_start) begin
          if (c == "[") begin
            do_open = 1'b1; open_kind = K_ARRAY;
          end else if (c == "{") begin
            do_open = 1'b1; open_kind = K_OBJECT;
          end else if ((c == "\"") || (c == "'")) begin
            push_en = 1'b1; push_kind = K_STRING; mode_d = M_IN_STRING; qs_d = (c == "'");
          end else if (cur.is_digit || (c == "-")) begin
            mode_d = M_NUMBER; sp_d = 1'b0; se_d = 1'b0;
            acc_d = cur.is_digit ? 64'(cur.hex_val) : 64'd0;
            neg_d = (c == "-"); prev_d = c;
            do_cont = 1'b1; cont_b = c; cont_ev = EV_NUM_BYTE;
          end else if (c == "t") begin
            mode_d = M_LIT_T; lit_d = 3'd1;
          end else if (c == "f") begin
            mode_d = M_LIT_F; lit_d = 3'd1;
          end else if (c == "n") begin
            mode_d = M_LIT_N; lit_d = 3'd1;
          end else begin
            evs[n[0]] = mk_ev(EV_ERROR, '0, '0, 1'b0, ERR_VALUE_CHAR); n = n + 2'd1;
            err_d = 1'b1;
          end
        end

        if (do_open) begin
          evs[n[0]] = mk_ev((open_kind == K_ARRAY) ? EV_ARR_START : EV_OBJ_START,
                            '0, '0, 1'b0, '0);
          n = n + 2'd1;
          mode_d = (open_kind == K_ARRAY) ? M_IN_ARRAY : M_IN_OBJECT;
          push_en = 1'b1; push_kind = open_kind;
        end

        if (do_close) begin
          if (top_none) begin
            evs[n[0]] = mk_ev(EV_ERROR, '0, '0, 1'b0,
                              (close_kind == K_ARRAY) ? ERR_ARR_EMPTY : ERR_OBJ_EMPTY);
            n = n + 2'd1; err_d = 1'b1;
          end else begin
            depth_d = depth_q - DW'(1); fetch = (depth_d != '0);
            if (top_q != close_kind) begin
              evs[n[0]] = mk_ev(EV_ERROR, '0, '0, 1'b0,
                                (close_kind == K_ARRAY) ? ERR_ARR_MISM : ERR_OBJ_MISM);
              n = n + 2'd1; err_d = 1'b1;
            end else begin
              evs[n[0]] = mk_ev((close_kind == K_ARRAY) ? EV_ARR_END : EV_OBJ_END,
                                '0, '0, 1'b0, '0);
              n = n + 2'd1; mode_d = M_AFTER_VALUE;
              if (depth_d == '0) begin
                evs[n[0]] = mk_ev(EV_END_DOC, '0, '0, 1'b0, '0); n = n + 2'd1;
                mode_d = M_START; cl_d = '0; hex_d = '0;
              end
            end
          end
        end

        if (do_cont) begin
          if (cl_d >= CL_LIM) begin
            evs[n[0]] = mk_ev(EV_ERROR, '0, '0, 1'b0, ERR_TOO_LONG); n = n + 2'd1;
            err_d = 1'b1;
          end else begin
            evs[n[0]] = mk_ev(cont_ev, cont_b, '0, 1'b0, '0); n = n + 2'd1;
            cl_d = cl_d + CW'(1);
          end
        end

        if (push_en && (depth_q < DEPTH_MAX)) begin
          depth_d = depth_q + DW'(1); top_d = push_kind;
        end
      end
    end
  end

  assign rd_idx = depth_d - DW'(1);

  jst_ram #(.WIDTH(2), .DEPTH(MAX_NEST_DEPTH)) u_stack (
    .clk_i   (clk_i),
    .we_i    (push_en && (depth_q < DEPTH_MAX)),
    .waddr_i (depth_q[AW-1:0]),
    .wdata_i (push_kind),
    .raddr_i (rd_idx[AW-1:0]),
    .rdata_o (ram_rd)
  );

  always_comb begin
    push_o = '0;
    pend_d = pend_q;
    pev_d  = pev_q;
    phase_d = phase_q;
    if (phase_q == PH_TOP) begin
      phase_d = PH_RUN;
    end else if (go) begin
      if (fetch) phase_d = PH_TOP;
      if (redo_d) begin
        pend_d = 1'b1; pev_d = evs[0];
      end else begin
        pend_d = 1'b0;
        if (pend_q) begin
          push_o.e0.ev = pev_q; push_o.e1.ev = evs[0]; push_o.e2.ev = evs[1];
          push_o.cnt = n + 2'd1;
        end else begin
          push_o.e0.ev = evs[0]; push_o.e1.ev = evs[1];
          push_o.cnt = n;
        end
        push_o.e0.last = (push_o.cnt == 2'd1);
        push_o.e1.last = (push_o.cnt == 2'd2);
        push_o.e2.last = (push_o.cnt == 2'd3);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && redo_d) cur_q <= cur;
    pev_q <= pev_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_START; phase_q <= PH_RUN; depth_q <= '0; cl_q <= '0;
      qs_q <= 1'b0; sp_q <= 1'b0; se_q <= 1'b0; neg_q <= 1'b0; err_q <= 1'b0;
      prev_q <= '0; acc_q <= '0; lit_q <= '0; hex_q <= '0; cp_q <= '0;
      top_q <= K_OBJECT; redo_q <= 1'b0; pend_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      pend_q  <= pend_d;
      if (phase_q == PH_TOP) begin
        top_q <= kind_e'(ram_rd);
      end else if (go) begin
        mode_q <= mode_d; depth_q <= depth_d; cl_q <= cl_d; qs_q <= qs_d;
        sp_q <= sp_d; se_q <= se_d; neg_q <= neg_d; err_q <= err_d; prev_q <= prev_d;
        acc_q <= acc_d; lit_q <= lit_d; hex_q <= hex_d; cp_q <= cp_d; top_q <= top_d;
        redo_q <= redo_d;
      end
    end
  end
endmodule

[src/jst_out_queue.sv]
// Event queue: take up to three events per cycle, deliver one beat per cycle while the sink is ready.
module jst_out_queue import jst_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  space_o,
  jst_out_if.source out_o
);
  out_t            ent_q [OQ_DEPTH];
  logic [OQ_AW-1:0] wptr_q, rptr_q;
  logic [OQ_AW:0]   cnt_q;
  logic             pop;
  out_t             head;

  assign space_o = (cnt_q <= (OQ_AW + 1)'(OQ_DEPTH - 3));
  assign head    = ent_q[rptr_q];
  assign pop     = out_o.valid && out_o.ready;

  assign out_o.valid      = (cnt_q != '0);
  assign out_o.event_res  = head.ev.event_res;
  assign out_o.data_byte  = head.ev.data_byte;
  assign out_o.int_value  = head.ev.int_value;
  assign out_o.is_float   = head.ev.is_float;
  assign out_o.error_code = head.ev.error_code;
  assign out_o.last       = head.last;

  always_ff @(posedge clk_i) begin
    if (push_i.cnt >= 2'd1) ent_q[wptr_q] <= push_i.e0;
    if (push_i.cnt >= 2'd2) ent_q[wptr_q + OQ_AW'(1)] <= push_i.e1;
    if (push_i.cnt == 2'd3) ent_q[wptr_q + OQ_AW'(2)] <= push_i.e2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_q + OQ_AW'(push_i.cnt);
      if (pop) rptr_q <= rptr_q + OQ_AW'(1);
      cnt_q <= cnt_q + (OQ_AW + 1)'(push_i.cnt) - (OQ_AW + 1)'(pop);
    end
  end
endmodule

[src/json_stream_tokenizer.sv]
// Streaming JSON tokenizer: one text byte per input beat in, SAX-style events out.
// A byte that closes a string, array or object and leaves the nesting stack non-empty
// is followed by a phase that refreshes the top of the stack from its RAM, and a byte
// that ends a number is parsed again after the number end event. Each byte yields zero
// to three events, delivered one beat per cycle while the sink is ready from an
// eight-entry event queue, so a steady stream of content bytes runs at one byte per
// cycle while the sink is ready and the event count per byte bounds the rate otherwise.
// The stack RAM needs no clearing after reset. A beat with action set restarts the
// parser.
module json_stream_tokenizer import jst_pkg::*; #(
  parameter int unsigned MAX_NEST_DEPTH   = 32,
  parameter int unsigned MAX_TOKEN_LENGTH = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  jst_in_if.sink    in_i,
  jst_out_if.source out_o
);
  logic  fe_valid, fe_ready, space;
  cls_t  fe_cls;
  push_t push;

  jst_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .valid_o (fe_valid),
    .ready_i (fe_ready),
    .cls_o   (fe_cls)
  );

  jst_engine #(
    .MAX_NEST_DEPTH   (MAX_NEST_DEPTH),
    .MAX_TOKEN_LENGTH (MAX_TOKEN_LENGTH)
  ) u_engine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fe_valid),
    .ready_o (fe_ready),
    .cls_i   (fe_cls),
    .space_i (space),
    .push_o  (push)
  );

  jst_out_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .space_o(space),
    .out_o  (out_o)
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.cnt != 2'd0) |-> space) else $error("event queue overflow");

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.event_res != EV_ERROR)) |-> (out_o.error_code == 5'd0))
    else $error("error code on non-error event");

  a_num_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.event_res != EV_NUM_END)) |->
    ((out_o.int_value == 64'sd0) && !out_o.is_float))
    else $error("number fields on non-number-end event");
endmodule

[bench/json_stream_tokenizer_tb.sv]
// Self-checking bench for the JSON stream tokenizer: random and directed documents.
`timescale 1ns / 1ps
module json_stream_tokenizer_tb;
  import jst_pkg::*;

  localparam int NEST_LIMIT = 32;
  localparam int TOKEN_LIMIT = 256;
  localparam int CYCLE_LIMIT = 400000;
  localparam bit [63:0] INT_CAP = 64'h8000_0000_0000_0000;

  localparam int M_START       = 0;
  localparam int M_IN_ARRAY    = 1;
  localparam int M_IN_OBJECT   = 2;
  localparam int M_END_KEY     = 3;
  localparam int M_AFTER_KEY   = 4;
  localparam int M_AFTER_VALUE = 5;
  localparam int M_IN_STRING   = 6;
  localparam int M_ESCAPE      = 7;
  localparam int M_UNICODE     = 8;
  localparam int M_NUMBER      = 9;
  localparam int M_LIT         = 10;
  localparam int M_LIT_BAD     = 13;
  localparam int K_NONE        = 4;

  class tokenizer_scoreboard;
    out_t       event_q[$];
    out_t       step_q[$];
    int         errors;
    int         checked;
    int         mode;
    kind_e      kinds[NEST_LIMIT];
    int         depth;
    int         tok_len;
    bit         quote_single;
    bit         seen_point;
    bit         seen_exp;
    bit [7:0]   prev_char;
    bit [63:0]  mantissa;
    bit         negative;
    int         lit_pos;
    int         hex_cnt;
    bit [15:0]  codepoint;
    bit         latched;
    string      lit_words[3] = '{"true", "false", "null"};

    function void restart();
      mode = M_START;
      depth = 0;
      tok_len = 0;
      quote_single = 0;
      seen_point = 0;
      seen_exp = 0;
      prev_char = 0;
      mantissa = 0;
      negative = 0;
      lit_pos = 0;
      hex_cnt = 0;
      codepoint = 0;
      latched = 0;
    endfunction

    function new();
      restart();
    endfunction

    function void emit(ev_e e, bit [7:0] b, bit [63:0] v, bit f, bit [4:0] er);
      out_t o;
      if (step_q.size() >= 4) return;
      o.ev.event_res = e;
      o.ev.data_byte = b;
      o.ev.int_value = v;
      o.ev.is_float = f;
      o.ev.error_code = er;
      o.last = 1'b0;
      step_q.push_back(o);
    endfunction

    function void fail(bit [4:0] er);
      emit(EV_ERROR, 0, 0, 0, er);
      latched = 1;
    endfunction

    function int top_kind();
      if (depth == 0 || depth > NEST_LIMIT) return K_NONE;
      return int'(kinds[depth-1]);
    endfunction

    function void push(kind_e k);
      if (depth < NEST_LIMIT) begin
        kinds[depth] = k;
        depth++;
      end
    endfunction

    function bit text_byte(bit [7:0] b, ev_e e);
      if (tok_len >= TOKEN_LIMIT - 1) begin
        fail(ERR_TOO_LONG);
        return 0;
      end
      emit(e, b, 0, 0, 0);
      tok_len++;
      return 1;
    endfunction

    function ev_e text_ev();
      return (top_kind() == int'(K_KEY)) ? EV_KEY_BYTE : EV_STR_BYTE;
    endfunction

    function void open_nest(kind_e k);
      emit(k == K_ARRAY ? EV_ARR_START : EV_OBJ_START, 0, 0, 0, 0);
      mode = (k == K_ARRAY) ? M_IN_ARRAY : M_IN_OBJECT;
      push(k);
    endfunction

    function void close_nest(kind_e k);
      bit [4:0] base;
      int t;
      base = (k == K_ARRAY) ? ERR_ARR_EMPTY : ERR_OBJ_EMPTY;
      if (depth == 0) begin
        fail(base);
        return;
      end
      t = top_kind();
      depth--;
      if (t != int'(k)) begin
        fail(base + 5'd1);
        return;
      end
      emit(k == K_ARRAY ? EV_ARR_END : EV_OBJ_END, 0, 0, 0, 0);
      mode = M_AFTER_VALUE;
      if (depth == 0) begin
        emit(EV_END_DOC, 0, 0, 0, 0);
        mode = M_START;
        tok_len = 0;
        hex_cnt = 0;
      end
    endfunction

    function void add_digit(bit [63:0] d);
      if (seen_point || seen_exp) return;
      if (mantissa > (INT_CAP - d) / 10) mantissa = INT_CAP;
      else mantissa = mantissa * 10 + d;
    endfunction

    function void end_number();
      bit [63:0] v;
      if (negative) v = 64'd0 - mantissa;
      else v = (mantissa > INT_CAP - 1) ? INT_CAP - 1 : mantissa;
      emit(EV_NUM_END, 0, v, seen_point, 0);
      tok_len = 0;
      mode = M_AFTER_VALUE;
    endfunction

    function void start_value(bit [7:0] c);
      if (c == "[") open_nest(K_ARRAY);
      else if (c == "{") open_nest(K_OBJECT);
      else if (c == "\"" || c == "'") begin
        push(K_STRING);
        mode = M_IN_STRING;
        quote_single = (c == "'");
      end else if ((c >= "0" && c <= "9") || c == "-") begin
        mode = M_NUMBER;
        seen_point = 0;
        seen_exp = 0;
        mantissa = 0;
        negative = (c == "-");
        if (c != "-") add_digit(c - "0");
        prev_char = c;
        void'(text_byte(c, EV_NUM_BYTE));
      end else if (c == "t" || c == "f" || c == "n") begin
        mode = M_LIT + ((c == "t") ? 0 : (c == "f") ? 1 : 2);
        lit_pos = 1;
      end else fail(ERR_VALUE_CHAR);
    endfunction

    function void end_unicode();
      ev_e e;
      e = text_ev();
      if (codepoint < 16'h80) void'(text_byte(codepoint[7:0], e));
      else if (codepoint < 16'h800) begin
        if (!text_byte(8'hC0 | codepoint[10:6], e)) return;
        void'(text_byte(8'h80 | codepoint[5:0], e));
      end else if (codepoint == 16'h2019) void'(text_byte("'", e));
      else void'(text_byte(" ", e));
      hex_cnt = 0;
      mode = M_IN_STRING;
    endfunction

    function void parse(bit [7:0] c);
      bit [7:0] delim;
      bit [7:0] esc;
      int t;
      int k;
      delim = quote_single ? "'" : "\"";
      if (latched) return;
      if (depth >= NEST_LIMIT - 1) begin
        fail(ERR_DEPTH);
        return;
      end
      if ((c == " " || c == 8'h09 || c == 8'h0A || c == 8'h0D) &&
          !(mode == M_IN_STRING || mode == M_UNICODE || mode == M_ESCAPE || mode == M_NUMBER))
        return;
      case (mode)
        M_START: begin
          emit(EV_START_DOC, 0, 0, 0, 0);
          if (c == "[") open_nest(K_ARRAY);
          else if (c == "{") open_nest(K_OBJECT);
          else fail(ERR_DOC_START);
        end
        M_IN_ARRAY: begin
          if (c == "]") close_nest(K_ARRAY);
          else start_value(c);
        end
        M_IN_OBJECT: begin
          if (c == "}") close_nest(K_OBJECT);
          else if (c == "\"" || c == "'") begin
            push(K_KEY);
            mode = M_IN_STRING;
            quote_single = (c == "'");
          end else fail(ERR_KEY_QUOTE);
        end
        M_END_KEY: begin
          if (c == ":") mode = M_AFTER_KEY;
          else fail(ERR_COLON);
        end
        M_AFTER_KEY: start_value(c);
        M_AFTER_VALUE: begin
          t = top_kind();
          if (t == int'(K_OBJECT)) begin
            if (c == "}") close_nest(K_OBJECT);
            else if (c == ",") mode = M_IN_OBJECT;
            else fail(ERR_OBJ_SEP);
          end else if (t == int'(K_ARRAY)) begin
            if (c == "]") close_nest(K_ARRAY);
            else if (c == ",") mode = M_IN_ARRAY;
            else fail(ERR_ARR_SEP);
          end else fail(ERR_NO_CONT);
        end
        M_IN_STRING: begin
          if (c == delim) begin
            t = top_kind();
            if (depth > 0) depth--;
            if (t == int'(K_KEY)) begin
              emit(EV_KEY_END, 0, 0, 0, 0);
              mode = M_END_KEY;
            end else begin
              emit(EV_STR_END, 0, 0, 0, 0);
              mode = M_AFTER_VALUE;
            end
            tok_len = 0;
            quote_single = 0;
          end else if (c == "\\") mode = M_ESCAPE;
          else if (c <= 8'h1F || c == 8'h7F) fail(ERR_CTRL_CHAR);
          else void'(text_byte(c, text_ev()));
        end
        M_ESCAPE: begin
          if (c == "u") begin
            mode = M_UNICODE;
            hex_cnt = 0;
            codepoint = 0;
          end else begin
            if (c == delim || c == "\\" || c == "/") esc = c;
            else if (c == "b") esc = 8'h08;
            else if (c == "f") esc = 8'h0C;
            else if (c == "n") esc = 8'h0A;
            else if (c == "r") esc = 8'h0D;
            else if (c == "t") esc = 8'h09;
            else begin
              fail(ERR_ESCAPE);
              return;
            end
            void'(text_byte(esc, text_ev()));
            mode = M_IN_STRING;
          end
        end
        M_UNICODE: begin
          if (c >= "0" && c <= "9") esc = c - "0";
          else if (c >= "a" && c <= "f") esc = c - "a" + 10;
          else if (c >= "A" && c <= "F") esc = c - "A" + 10;
          else begin
            fail(ERR_HEX);
            return;
          end
          codepoint = {codepoint[11:0], esc[3:0]};
          hex_cnt++;
          if (hex_cnt >= 4) end_unicode();
        end
        M_NUMBER: begin
          if (c >= "0" && c <= "9") add_digit(c - "0");
          else if (c == ".") begin
            if (seen_point) begin fail(ERR_TWO_POINTS); return; end
            if (seen_exp) begin fail(ERR_POINT_EXP); return; end
            seen_point = 1;
          end else if (c == "e" || c == "E") begin
            if (seen_exp) begin fail(ERR_TWO_EXP); return; end
            seen_exp = 1;
          end else if (c == "+" || c == "-") begin
            if (tok_len == 0) begin fail(ERR_SIGN_EMPTY); return; end
            if (!(prev_char == "e" || prev_char == "E")) begin
              fail(ERR_SIGN_POS);
              return;
            end
          end else begin
            end_number();
            parse(c);
            return;
          end
          prev_char = c;
          void'(text_byte(c, EV_NUM_BYTE));
        end
        default: begin
          if (mode < M_LIT || mode > M_LIT_BAD + 2) return;
          k = (mode - M_LIT) % 3;
          if (lit_pos < lit_words[k].len() && c != lit_words[k][lit_pos] && mode < M_LIT_BAD)
            mode = M_LIT_BAD + k;
          lit_pos++;
          if (lit_pos >= lit_words[k].len()) begin
            if (mode >= M_LIT_BAD) fail(ERR_TRUE + k);
            else begin
              emit(ev_e'(int'(EV_TRUE) + k), 0, 0, 0, 0);
              mode = M_AFTER_VALUE;
              lit_pos = 0;
            end
          end
        end
      endcase
    endfunction

    function void note_beat(bit act, bit [7:0] b);
      step_q.delete();
      if (act) begin
        restart();
        return;
      end
      parse(b);
      if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
      foreach (step_q[i]) event_q.push_back(step_q[i]);
    endfunction

    function void check_beat(out_t got);
      out_t want;
      checked++;
      if (event_q.size() == 0) begin
        $error("unexpected event %0d", got.ev.event_res);
        errors++;
        return;
      end
      want = event_q.pop_front();
      if (got.ev.event_res !== want.ev.event_res) begin
        $error("event_res: expected %0d, got %0d", want.ev.event_res, got.ev.event_res);
        errors++;
      end
      if (got.ev.data_byte !== want.ev.data_byte) begin
        $error("data_byte: expected %h, got %h", want.ev.data_byte, got.ev.data_byte);
        errors++;
      end
      if (got.ev.int_value !== want.ev.int_value) begin
        $error("int_value: expected %0d, got %0d", want.ev.int_value, got.ev.int_value);
        errors++;
      end
      if (got.ev.is_float !== want.ev.is_float) begin
        $error("is_float: expected %0b, got %0b", want.ev.is_float, got.ev.is_float);
        errors++;
      end
      if (got.ev.error_code !== want.ev.error_code) begin
        $error("error_code: expected %0d, got %0d", want.ev.error_code, got.ev.error_code);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   cycles = 0;
  int   src_idle = 0;
  int   snk_idle = 0;
  int   hold_req = 0;
  int   beats = 0;
  int   docs = 0;
  bit [7:0] doc_q[$];
  tokenizer_scoreboard sb = new();

  jst_in_if  in_if ();
  jst_out_if out_if ();

  json_stream_tokenizer dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("json_stream_tokenizer test failed");
      $finish;
    end
  end

  initial begin
    out_t got;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        got.ev.event_res = ev_e'(out_if.event_res);
        got.ev.data_byte = out_if.data_byte;
        got.ev.int_value = out_if.int_value;
        got.ev.is_float = out_if.is_float;
        got.ev.error_code = out_if.error_code;
        got.last = out_if.last;
        sb.check_beat(got);
      end
      if (hold_req > 0) begin
        out_if.ready <= 1'b0;
        hold_req--;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= snk_idle);
      end
    end
  end

  task automatic send_beat(bit act, bit [7:0] b);
    while ($urandom_range(0, 99) < src_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.action <= act;
    in_if.byte_in <= b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_beat(act, b);
    beats++;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.event_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_doc();
    send_beat(1'b1, 8'($urandom));
    foreach (doc_q[i]) send_beat(1'b0, doc_q[i]);
    doc_q.delete();
    docs++;
  endtask

  function automatic void put(string s);
    foreach (s[i]) doc_q.push_back(s[i]);
  endfunction

  function automatic void put_ws();
    string ws = " \t\n\r";
    if ($urandom_range(0, 4) == 0) doc_q.push_back(ws[$urandom_range(0, 3)]);
  endfunction

  function automatic void gen_text();
    bit [7:0] q;
    bit [7:0] c;
    string esc = "\\/bfnrt";
    int n;
    q = ($urandom_range(0, 3) == 0) ? "'" : "\"";
    doc_q.push_back(q);
    n = $urandom_range(0, 6);
    repeat (n) begin
      case ($urandom_range(0, 9))
        0: begin
          doc_q.push_back("\\");
          if ($urandom_range(0, 3) == 0) doc_q.push_back(q);
          else doc_q.push_back(esc[$urandom_range(0, esc.len() - 1)]);
        end
        1: begin
          put("\\u");
          case ($urandom_range(0, 3))
            0: put($sformatf("%04x", $urandom_range(0, 8'h7F)));
            1: put($sformatf("%04X", $urandom_range(8'h80, 16'h7FF)));
            2: put("2019");
            default: put($sformatf("%04x", $urandom_range(0, 16'hFFFF)));
          endcase
        end
        2: doc_q.push_back(8'($urandom_range(8'h80, 8'hFF)));
        default: begin
          do c = 8'($urandom_range(8'h20, 8'h7E)); while (c == q || c == "\\");
          doc_q.push_back(c);
        end
      endcase
    end
    doc_q.push_back(q);
  endfunction

  function automatic void gen_digits(int n);
    repeat (n) doc_q.push_back(8'("0" + $urandom_range(0, 9)));
  endfunction

  function automatic void gen_number();
    if ($urandom_range(0, 2) == 0) doc_q.push_back("-");
    gen_digits(($urandom_range(0, 9) == 0) ? $urandom_range(18, 22) : $urandom_range(1, 3));
    if ($urandom_range(0, 2) == 0) begin
      doc_q.push_back(".");
      gen_digits($urandom_range(1, 2));
    end
    if ($urandom_range(0, 3) == 0) begin
      doc_q.push_back($urandom_range(0, 1) ? "e" : "E");
      case ($urandom_range(0, 2))
        0: doc_q.push_back("+");
        1: doc_q.push_back("-");
        default: ;
      endcase
      gen_digits($urandom_range(1, 2));
    end
  endfunction

  function automatic void gen_value(int lvl);
    int n;
    int r;
    r = $urandom_range(0, 7);
    if (lvl < 3 && r == 0) begin
      doc_q.push_back("[");
      n = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) begin
        if (i > 0) doc_q.push_back(",");
        put_ws();
        gen_value(lvl + 1);
        put_ws();
      end
      doc_q.push_back("]");
    end else if (lvl < 3 && r == 1) begin
      doc_q.push_back("{");
      n = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) begin
        if (i > 0) doc_q.push_back(",");
        put_ws();
        gen_text();
        put_ws();
        doc_q.push_back(":");
        gen_value(lvl + 1);
      end
      if (n > 0 && $urandom_range(0, 4) == 0) doc_q.push_back(",");
      doc_q.push_back("}");
    end else if (r <= 3) gen_text();
    else if (r <= 5) gen_number();
    else begin
      case ($urandom_range(0, 2))
        0: put("true");
        1: put("false");
        default: put("null");
      endcase
    end
  endfunction

  function automatic void gen_doc();
    string noise = "{}[],:\"'\\.eE+-tfn0 ";
    int p;
    if ($urandom_range(0, 1)) begin
      doc_q.push_back("[");
      gen_value(1);
      put(",");
      gen_value(1);
      doc_q.push_back("]");
    end else begin
      put("{\"k\":");
      gen_value(1);
      doc_q.push_back("}");
    end
    put_ws();
    if ($urandom_range(0, 3) == 0) begin
      p = $urandom_range(0, doc_q.size() - 1);
      case ($urandom_range(0, 2))
        0: doc_q[p] = 8'($urandom);
        1: doc_q.delete(p);
        default: doc_q.insert(p, noise[$urandom_range(0, noise.len() - 1)]);
      endcase
    end
  endfunction

  task automatic random_phase(int nbytes);
    int start;
    start = beats;
    while (beats - start < nbytes) begin
      gen_doc();
      send_doc();
      if ($urandom_range(0, 5) == 0) drain();
    end
  endtask

  initial begin
    in_if.valid <= 1'b0;
    in_if.action <= 1'b0;
    in_if.byte_in <= 8'h00;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    put("{'k':[-0,1.5e3,tru,\"\\u2019\\u00e9\x01\"]}");
    send_doc();
    put("x[-+]");
    send_doc();
    repeat (32) doc_q.push_back("[");
    send_doc();
    drain();

    src_idle = 23;
    snk_idle = 79;
    hold_req = 400;
    random_phase(60);
    drain();
    src_idle = 79;
    snk_idle = 23;
    random_phase(60);
    drain();
    src_idle = 0;
    snk_idle = 0;
    random_phase(60);
    drain();
    repeat (20) @(posedge clk);

    $display("Sent %0d beats in %0d documents, checked %0d events.", beats, docs, sb.checked);
    $display("Covered nesting, escapes, numbers, literals, errors and output stalls.");
    if (sb.errors == 0 && sb.event_q.size() == 0) begin
      $display("json_stream_tokenizer test passed");
    end else begin
      $display("json_stream_tokenizer test failed");
    end
    $finish;
  end

endmodule
